[sv/assert_macros.svh]
// assertion helpers used by the checker in pngpd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, masked while reset is high
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that is also checked across reset
`define ASSERT_NEXT_ANY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/pngpd_pkg.sv]
package pngpd_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 4096;
  localparam int MAX_PIXEL_BYTES_DEF = 64;

  localparam int MODE_W     = 4;
  localparam int COLOR_W    = 6;
  localparam int BITS_W     = 5;
  localparam int COLS_W     = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CB_W       = 11;   // colors * bits
  localparam int CBC_W      = 24;   // columns * colors * bits

  localparam logic [CFG_IDX_W-1:0] REG_PREDICTOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLORS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BITS      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] NUM_REGS      = CFG_IDX_W'(4);

  localparam logic [MODE_W-1:0]  PNG_MODE_MIN = MODE_W'(10);
  localparam logic [MODE_W-1:0]  MODE_RESET   = MODE_W'(1);
  localparam logic [COLOR_W-1:0] COLOR_RESET  = COLOR_W'(1);
  localparam logic [BITS_W-1:0]  BITS_RESET   = BITS_W'(8);
  localparam logic [BITS_W-1:0]  BITS_ZERO_AS = BITS_W'(8);
  localparam logic [COLS_W-1:0]  COLS_RESET   = COLS_W'(1);

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH
  } filter_t;

  localparam logic [7:0] TAG_MAX = 8'd4;

endpackage

[sv/pngpd_filter.sv]
module pngpd_filter
  import pngpd_pkg::*;
(
  input  filter_t    filter,
  input  logic [7:0] raw,
  input  logic [7:0] left,
  input  logic [7:0] above,
  input  logic [7:0] corner,
  output logic [7:0] decoded
);

  logic [8:0]        avg_sum;
  logic signed [9:0] da, db, dc;
  logic [9:0]        pa, pb, pc;
  logic [7:0]        paeth_pred;
  logic [7:0]        pred;

  // pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
  always_comb begin
    da = $signed({2'b00, above}) - $signed({2'b00, corner});
    db = $signed({2'b00, left}) - $signed({2'b00, corner});
    dc = da + db;
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    priority if (pa <= pb && pa <= pc) begin
      paeth_pred = left;
    end else if (pb <= pc) begin
      paeth_pred = above;
    end else begin
      paeth_pred = corner;
    end
  end

  assign avg_sum = {1'b0, left} + {1'b0, above};

  always_comb begin
    unique case (filter)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = above;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth_pred;
      default:    pred = 8'd0;
    endcase
  end

  assign decoded = raw + pred;

endmodule

[sv/png_predictor_decoder.sv]
// an accepted data byte passes the s1 stage register, then the output register, to m_tvalid
// one byte per cycle unless the output stalls or a recompute runs; a filter tag gives no result
// row bytes sit in a registered-read ram; a per-phase ram holds left and upper-left bytes
// writing a known register holds both ports off through the CALC_PIX/ROW/DONE length recompute
// reset (rst, synchronous): registers to defaults, first row awaiting a tag; rams are not cleared
module png_predictor_decoder
  import pngpd_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // data_byte
  input  logic                  s_tlast,   // last_of_stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // out_byte
  output logic                  m_tuser,   // row_end
  output logic                  m_tlast,   // stream_end
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int RLW  = $clog2(MAX_ROW_BYTES + 1);
  localparam int PW   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int PLW  = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int CMPW = (RLW > PLW) ? RLW : PLW;

  typedef enum logic [1:0] {
    CALC_IDLE,
    CALC_PIX,
    CALC_ROW,
    CALC_DONE
  } calc_state_t;

  // configuration
  logic [MODE_W-1:0]  predictor_mode;
  logic [COLOR_W-1:0] color_count;
  logic [BITS_W-1:0]  bits_per_component;
  logic [COLS_W-1:0]  column_count;
  calc_state_t        calc_state;
  logic [CB_W-1:0]    cb;
  logic [CBC_W-1:0]   cbc;
  logic [PLW-1:0]     pixel_length;
  logic [RLW-1:0]     row_length;

  // stream position
  logic [CW-1:0] column_position;
  logic [PW-1:0] phase;
  logic          awaiting_tag;
  filter_t       row_filter;
  logic          first_row;

  // stage after the ram read
  logic          s1_valid;
  logic          s1_pass;
  logic [7:0]    s1_byte;
  filter_t       s1_filter;
  logic          s1_edge;
  logic          s1_first;
  logic          s1_last;
  logic          s1_done;
  logic          s1_fwd;
  logic [CW-1:0] s1_col;
  logic [PW-1:0] s1_phase;
  logic [7:0]    above_rd;
  logic [15:0]   hist_rd;
  logic [7:0]    prev_decoded, prev_above;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_row_end;
  logic       out_stream_end;

  logic [7:0]  above_mem [MAX_ROW_BYTES];
  // upper byte: above byte, lower byte: decoded byte of the same phase
  logic [15:0] hist_mem  [MAX_PIXEL_BYTES];

  logic              png_mode;
  logic              in_acc, cfg_acc, cfg_known;
  logic              data_acc, s1_adv, s1_write;
  logic              edge_now, row_done_now, fwd_now;
  logic [PW-1:0]     phase_inc;
  logic [COLOR_W-1:0] colors_eff;
  logic [BITS_W-1:0]  bits_eff;
  logic [COLS_W-1:0]  cols_eff;
  logic [CB_W:0]      pix_raw;
  logic [CBC_W:0]     row_raw;
  logic [7:0]         s1_left, s1_ul, s1_above, s1_decoded, s1_result;

  assign png_mode  = (predictor_mode >= PNG_MODE_MIN);
  assign cfg_ready = (calc_state == CALC_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index < NUM_REGS);

  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s1_write = s1_adv && !s1_pass;
  assign s_tready = (calc_state == CALC_IDLE) && (!s1_valid || s1_adv);
  assign in_acc   = s_tvalid && s_tready;
  assign data_acc = in_acc && png_mode && !awaiting_tag;

  assign edge_now     = CMPW'(column_position) < CMPW'(pixel_length);
  assign row_done_now = (RLW'(column_position) + RLW'(1)) >= row_length;
  assign phase_inc    = ((PLW'(phase) + PLW'(1)) >= pixel_length) ? '0 : phase + PW'(1);
  // the entry this byte reads is being written by the byte ahead of it
  assign fwd_now      = s1_write && (s1_phase == phase);

  assign colors_eff = (color_count == '0) ? COLOR_W'(1) : color_count;
  assign bits_eff   = (bits_per_component == '0) ? BITS_ZERO_AS : bits_per_component;
  assign cols_eff   = (column_count == '0) ? COLS_W'(1) : column_count;
  assign pix_raw    = ((CB_W + 1)'(cb) + (CB_W + 1)'(7)) >> 3;
  assign row_raw    = ((CBC_W + 1)'(cbc) + (CBC_W + 1)'(7)) >> 3;

  // control, configuration and length recompute
  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_mode     <= MODE_RESET;
      color_count        <= COLOR_RESET;
      bits_per_component <= BITS_RESET;
      column_count       <= COLS_RESET;
      calc_state         <= CALC_IDLE;
      pixel_length       <= PLW'(1);
      row_length         <= RLW'(1);
      column_position    <= '0;
      phase              <= '0;
      awaiting_tag       <= 1'b1;
      row_filter         <= FILT_NONE;
      first_row          <= 1'b1;
    end else begin
      unique case (calc_state)
        CALC_PIX: begin
          cb         <= CB_W'(colors_eff) * CB_W'(bits_eff);
          calc_state <= CALC_ROW;
        end
        CALC_ROW: begin
          cbc          <= CBC_W'(cols_eff) * CBC_W'(cb);
          pixel_length <= (pix_raw > (CB_W + 1)'(MAX_PIXEL_BYTES)) ?
                          PLW'(MAX_PIXEL_BYTES) : PLW'(pix_raw);
          calc_state   <= CALC_DONE;
        end
        CALC_DONE: begin
          row_length <= (row_raw > (CBC_W + 1)'(MAX_ROW_BYTES)) ?
                        RLW'(MAX_ROW_BYTES) : RLW'(row_raw);
          calc_state <= CALC_IDLE;
        end
        default: begin
          if (cfg_acc && cfg_known) begin
            calc_state <= CALC_PIX;
          end
        end
      endcase

      // a write to a known register or an end of stream in png mode restarts in first-row state
      if (cfg_acc && cfg_known) begin
        column_position <= '0;
        phase           <= '0;
        awaiting_tag    <= 1'b1;
        row_filter      <= FILT_NONE;
        first_row       <= 1'b1;
      end else if (in_acc && png_mode) begin
        if (s_tlast) begin
          column_position <= '0;
          phase           <= '0;
          awaiting_tag    <= 1'b1;
          row_filter      <= FILT_NONE;
          first_row       <= 1'b1;
        end else if (awaiting_tag) begin
          row_filter      <= (s_tdata <= TAG_MAX) ? filter_t'(s_tdata[2:0]) : FILT_NONE;
          awaiting_tag    <= 1'b0;
          column_position <= '0;
          phase           <= '0;
        end else if (row_done_now) begin
          column_position <= '0;
          phase           <= '0;
          awaiting_tag    <= 1'b1;
          first_row       <= 1'b0;
        end else begin
          column_position <= column_position + CW'(1);
          phase           <= phase_inc;
        end
      end

      if (cfg_acc) begin
        unique case (cfg_index)
          REG_PREDICTOR: predictor_mode     <= cfg_data[MODE_W-1:0];
          REG_COLORS:    color_count        <= cfg_data[COLOR_W-1:0];
          REG_BITS:      bits_per_component <= cfg_data[BITS_W-1:0];
          REG_COLUMNS:   column_count       <= cfg_data[COLS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // rams: read on the request, written back when the decoded byte leaves the stage
  always_ff @(posedge clk) begin
    if (data_acc) begin
      above_rd <= above_mem[column_position];
      hist_rd  <= hist_mem[phase];
    end
    if (s1_write) begin
      above_mem[s1_col]  <= s1_decoded;
      hist_mem[s1_phase] <= {s1_above, s1_decoded};
      prev_decoded       <= s1_decoded;
      prev_above         <= s1_above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc && (!png_mode || !awaiting_tag)) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pass   <= !png_mode;
      s1_byte   <= s_tdata;
      s1_filter <= row_filter;
      s1_edge   <= edge_now;
      s1_first  <= first_row;
      s1_last   <= s_tlast;
      s1_done   <= png_mode && row_done_now;
      s1_fwd    <= fwd_now;
      s1_col    <= column_position;
      s1_phase  <= phase;
    end
  end

  assign s1_left  = s1_edge ? 8'd0 : (s1_fwd ? prev_decoded : hist_rd[7:0]);
  assign s1_ul    = s1_edge ? 8'd0 : (s1_fwd ? prev_above : hist_rd[15:8]);
  assign s1_above = s1_first ? 8'd0 : above_rd;

  pngpd_filter u_filter (
    .filter  (s1_filter),
    .raw     (s1_byte),
    .left    (s1_left),
    .above   (s1_above),
    .corner  (s1_ul),
    .decoded (s1_decoded)
  );

  assign s1_result = s1_pass ? s1_byte : s1_decoded;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte       <= s1_result;
      out_row_end    <= s1_done;
      out_stream_end <= s1_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = out_row_end;
  assign m_tlast  = out_stream_end;

endmodule

[sv/pngpd_checker.sv]
`include "assert_macros.svh"

module pngpd_checker
  import pngpd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [7:0]            s_tdata,
  input logic                  s_tlast,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [7:0]            m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "result changed while stalled")

  // reset empties the output and frees the register port
  `ASSERT_NEXT_ANY(a_reset_clear, rst, !m_tvalid && cfg_ready,
    "output or register port not idle after reset")

  // a write to a known register holds off both ports while lengths are recomputed
  `ASSERT_NEXT(a_cfg_busy, cfg_valid && cfg_ready && cfg_index < NUM_REGS,
    !s_tready && !cfg_ready, "ports open during length recompute")

endmodule

bind png_predictor_decoder pngpd_checker u_pngpd_checker (.*);

[tb/png_predictor_decoder_checker.sv]
`timescale 1ns / 100ps

module png_predictor_decoder_checker
  import pngpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // data_byte
  input  logic                  s_tlast,   // last_of_stream
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [7:0]            m_tdata,   // out_byte
  input  logic                  m_tuser,   // row_end
  input  logic                  m_tlast,   // stream_end
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    rows_done,
  output int                    row_len,
  output logic                  png_mode
);

  localparam int ROW_MAX      = MAX_ROW_BYTES_DEF;
  localparam int PIX_MAX      = MAX_PIXEL_BYTES_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       row_end;
    logic       stream_end;
  } decoded_t;

  logic [MODE_W-1:0]  mode_reg;
  logic [COLOR_W-1:0] colors_reg;
  logic [BITS_W-1:0]  bits_reg;
  logic [COLS_W-1:0]  cols_reg;
  int                 row_size;
  int                 pixel_bytes;

  logic [7:0] above_mem  [ROW_MAX];
  logic [7:0] left_mem   [PIX_MAX];
  logic [7:0] upleft_mem [PIX_MAX];
  int         col;
  int         phase;
  bit         want_tag;
  bit         first_row;
  filter_t    filt;

  decoded_t decoded_q[$];
  int       mismatches = 0;
  int       n_checked = 0;
  int       n_rows = 0;

  assign fail_count = mismatches;
  assign checked    = n_checked;
  assign rows_done  = n_rows;
  assign row_len    = row_size;
  assign png_mode   = (mode_reg >= PNG_MODE_MIN);

  function automatic int paeth_pick(int a, int b, int c);
    int p, pa, pb, pc;
    p  = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  function automatic void set_lengths();
    int colors, bits, cols, pix, row;
    colors = (colors_reg == 0) ? 1 : int'(colors_reg);
    bits   = (bits_reg == 0) ? int'(BITS_ZERO_AS) : int'(bits_reg);
    cols   = (cols_reg == 0) ? 1 : int'(cols_reg);
    pix    = (colors * bits + 7) / 8;
    row    = (cols * colors * bits + 7) / 8;
    pixel_bytes = (pix > PIX_MAX) ? PIX_MAX : pix;
    row_size    = (row > ROW_MAX) ? ROW_MAX : row;
  endfunction

  function automatic void restart_stream();
    col       = 0;
    phase     = 0;
    want_tag  = 1'b1;
    filt      = FILT_NONE;
    first_row = 1'b1;
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PREDICTOR: mode_reg = data[MODE_W-1:0];
      REG_COLORS:    colors_reg = data[COLOR_W-1:0];
      REG_BITS:      bits_reg = data[BITS_W-1:0];
      REG_COLUMNS:   cols_reg = data[COLS_W-1:0];
      default:       return;
    endcase
    set_lengths();
    restart_stream();
  endfunction

  function automatic void decode_byte(logic [7:0] raw, logic last);
    decoded_t d;
    int       left, above, upleft, pred;
    bit       at_edge;
    if (mode_reg < PNG_MODE_MIN) begin
      d.value      = raw;
      d.row_end    = 1'b0;
      d.stream_end = last;
      decoded_q.push_back(d);
      return;
    end
    if (want_tag) begin
      filt     = (raw <= TAG_MAX) ? filter_t'(raw[2:0]) : FILT_NONE;
      want_tag = 1'b0;
      col      = 0;
      phase    = 0;
      if (last) restart_stream();
      return;
    end
    // left and upper-left read zero within the first pixel of a row
    at_edge = (col < pixel_bytes);
    left    = at_edge ? 0 : int'(left_mem[phase]);
    upleft  = at_edge ? 0 : int'(upleft_mem[phase]);
    above   = first_row ? 0 : int'(above_mem[col]);
    case (filt)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = above;
      FILT_AVG:   pred = (left + above) >> 1;
      FILT_PAETH: pred = paeth_pick(left, above, upleft);
      default:    pred = 0;
    endcase
    d.value = 8'(int'(raw) + pred);
    left_mem[phase]   = d.value;
    upleft_mem[phase] = 8'(above);
    above_mem[col]    = d.value;
    phase = (phase + 1 >= pixel_bytes) ? 0 : phase + 1;
    d.row_end = (col + 1 >= row_size);
    if (d.row_end) begin
      col       = 0;
      phase     = 0;
      want_tag  = 1'b1;
      first_row = 1'b0;
    end else begin
      col++;
    end
    if (last) restart_stream();
    d.stream_end = last;
    decoded_q.push_back(d);
  endfunction

  function automatic void check_result();
    decoded_t got, want;
    got = {m_tdata, m_tuser, m_tlast};
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected result byte %02h row_end %0b stream_end %0b",
                 $time, got.value, got.row_end, got.stream_end);
      return;
    end
    want = decoded_q.pop_front();
    n_checked++;
    if (want.row_end) n_rows++;
    if (got.value != want.value || got.row_end != want.row_end ||
        got.stream_end != want.stream_end) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: mismatch, expected %02h/%0b/%0b got %02h/%0b/%0b (byte/row/stream)",
                 $time, want.value, want.row_end, want.stream_end,
                 got.value, got.row_end, got.stream_end);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode_reg   = MODE_RESET;
      colors_reg = COLOR_RESET;
      bits_reg   = BITS_RESET;
      cols_reg   = COLS_RESET;
      set_lengths();
      restart_stream();
      decoded_q.delete();
      pending <= 0;
    end else begin
      // results leave before new requests are predicted
      if (m_tvalid && m_tready) check_result();
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      pending <= decoded_q.size();
    end
  end

endmodule

[tb/png_predictor_decoder_tb.sv]
`timescale 1ns / 100ps

module png_predictor_decoder_tb;
  import pngpd_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int TARGET_BYTES = 1000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   fail_count, pending, checked, rows_done, row_len;
  logic png_mode;
  bit   quiet = 1'b0;
  int   sink_hold = 0;
  int   bytes_sent = 0;
  int   reg_writes = 0;

  png_predictor_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  png_predictor_decoder_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .rows_done  (rows_done),
    .row_len    (row_len),
    .png_mode   (png_mode)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int draw_wait();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic int pick4(int a, int b, int c, int d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  // output side: after each result, drop m_tready for a random wait that may be zero
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_tvalid && m_tready) sink_hold = draw_wait();
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    // hold the request until the block takes it
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a trailing tag gives no result, so give the pipe time to drain
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic pick_setting();
    case ($urandom_range(0, 9))
      0: begin
        write_reg(REG_PREDICTOR, pick4(0, 9, 10, 15));
        write_reg(REG_COLORS, pick4(0, 1, 32, 63));
        write_reg(REG_BITS, pick4(0, 1, 16, 31));
        write_reg(REG_COLUMNS, pick4(0, 1, 4096, 8191));
      end
      1: begin
        write_reg(REG_PREDICTOR, $urandom_range(10, 15));
        write_reg(REG_COLORS, $urandom_range(0, 63));
        write_reg(REG_BITS, $urandom_range(0, 31));
        write_reg(REG_COLUMNS, $urandom_range(0, 8191));
      end
      2: begin
        write_reg(REG_PREDICTOR, $urandom_range(10, 15));
        write_reg(REG_COLORS, $urandom_range(1, 3));
        write_reg(REG_BITS, 8);
        write_reg(REG_COLUMNS, $urandom_range(8, 80));
      end
      default: begin
        write_reg(REG_PREDICTOR, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9)
                                                            : $urandom_range(10, 15));
        if ($urandom_range(0, 1)) write_reg(REG_COLORS, $urandom_range(0, 4));
        if ($urandom_range(0, 1)) write_reg(REG_BITS, pick4(0, 1, 16, $urandom_range(2, 8)));
        write_reg(REG_COLUMNS, $urandom_range(0, 6));
      end
    endcase
    // index past the register file must leave everything alone
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), $urandom_range(0, 8191));
  endtask

  task automatic send_stream();
    int rows, n, tag;
    bit closing, partial;
    rows = $urandom_range(1, 4);
    for (int r = 0; r < rows; r++) begin
      closing = (r == rows - 1) && ($urandom_range(0, 2) != 0);
      tag = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
      if (closing && $urandom_range(0, 7) == 0) begin
        send_byte(8'(tag), 1'b1);
        return;
      end
      send_byte(8'(tag), 1'b0);
      // long rows are only ever cut short by an end of stream
      partial = (row_len > 1) && (row_len > 300 || $urandom_range(0, 5) == 0);
      n = partial ? $urandom_range(1, (row_len > 41) ? 40 : row_len - 1) : row_len;
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), (partial || closing) && i == n - 1);
      if (partial) return;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset setting passes bytes through
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b0);
    settle();

    write_reg(REG_PREDICTOR, 10);
    write_reg(REG_COLORS, 1);
    write_reg(REG_BITS, 8);
    write_reg(REG_COLUMNS, 2);
    // one row per filter, then an out-of-range tag decoded as none
    for (int f = 0; f < 6; f++) begin
      send_byte((f == 5) ? 8'hC8 : 8'(f), 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
    end
    send_byte(8'h04, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);

    while (bytes_sent < TARGET_BYTES) begin
      settle();
      quiet = ($urandom_range(0, 4) == 0);
      pick_setting();
      if (png_mode)
        repeat ($urandom_range(1, 4))
          if (bytes_sent < TARGET_BYTES) send_stream();
      else
        repeat ($urandom_range(10, 40))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end

    settle();
    repeat (12) @(posedge clk);
    $display("streamed %0d bytes under %0d register writes", bytes_sent, reg_writes);
    $display("compared %0d decoded bytes, %0d of them closing a row", checked, rows_done);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
